### hdl/csv_field_tokenizer_assert.svh
// Assertion macros shared by the checker files of the CSV field tokenizer.
`ifndef CSV_FIELD_TOKENIZER_ASSERT_SVH
`define CSV_FIELD_TOKENIZER_ASSERT_SVH

// Concurrent check on clk that is switched off while reset is held.
`define CSVT_ASSERT(name, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("csv_field_tokenizer: assertion failed");

// Concurrent check on clk that also runs while reset is held.
`define CSVT_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("csv_field_tokenizer: reset assertion failed");

`endif

### hdl/csvt_pkg.sv
// Package with the types and constants of the CSV field tokenizer.
package csvt_pkg;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_NUL   = 8'h00;

  localparam int QUEUE_AW    = 2;
  localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

  typedef enum logic [1:0] {
    EV_DATA  = 2'd0,
    EV_FIELD = 2'd1,
    EV_ROW   = 2'd2
  } event_kind_t;

  // Results caused by one accepted byte: one or two events.
  typedef struct packed {
    logic        two_events;
    event_kind_t kind0;
    logic [7:0]  byte0;
    event_kind_t kind1;
    logic [7:0]  byte1;
  } plan_t;

endpackage

### hdl/csvt_ifs.sv
// Channel interfaces for the input bytes and the tokenizer events.
interface csvt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_input;

  modport source (output valid, output text_byte, output end_of_input, input ready);
  modport sink (input valid, input text_byte, input end_of_input, output ready);
endinterface

interface csvt_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] event_kind;
  logic [7:0] data_byte;
  logic       last_of_run;

  modport source (output valid, output event_kind, output data_byte, output last_of_run,
                  input ready);
  modport sink (input valid, input event_kind, input data_byte, input last_of_run,
                output ready);
endinterface

### hdl/csvt_front.sv
// Front end: parser flags and classification of each byte into an event plan.
module csvt_front import csvt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  csvt_in_if.sink     in_ch,
  output plan_t       push_plan,
  output logic        push_valid,
  input  logic        push_ready
);

  logic in_quoted_r, in_quoted_nxt;
  logic field_start_r, field_start_nxt;
  logic quote_pend_r, quote_pend_nxt;
  logic cr_pend_r, cr_pend_nxt;
  logic has_bytes_r, has_bytes_nxt;
  logic [1:0] ev_count;
  logic accept;

  always_comb begin
    event_kind_t kind_v [2];
    logic [7:0]  byte_v [2];
    logic        done;
    logic        is_end;
    logic [7:0]  b;

    b       = in_ch.text_byte;
    is_end  = in_ch.end_of_input || (b == CH_NUL);
    kind_v[0] = EV_DATA;
    kind_v[1] = EV_DATA;
    byte_v[0] = CH_NUL;
    byte_v[1] = CH_NUL;
    ev_count  = 2'd0;
    done      = 1'b0;

    in_quoted_nxt   = in_quoted_r;
    field_start_nxt = field_start_r;
    quote_pend_nxt  = 1'b0;
    cr_pend_nxt     = 1'b0;
    has_bytes_nxt   = has_bytes_r;

    // Resolve the byte of lookahead held from the previous transaction.
    if (quote_pend_r) begin
      if (!is_end && b == CH_QUOTE) begin
        kind_v[0]     = EV_DATA;
        byte_v[0]     = CH_QUOTE;
        ev_count      = 2'd1;
        has_bytes_nxt = 1'b1;
        done          = 1'b1;
      end else begin
        in_quoted_nxt = 1'b0;
      end
    end else if (cr_pend_r) begin
      if (!is_end && b == CH_LF) begin
        kind_v[0]       = EV_ROW;
        ev_count        = 2'd1;
        has_bytes_nxt   = 1'b0;
        field_start_nxt = 1'b1;
        done            = 1'b1;
      end else begin
        kind_v[0]     = EV_DATA;
        byte_v[0]     = CH_CR;
        ev_count      = 2'd1;
        has_bytes_nxt = 1'b1;
      end
    end

    if (!done && is_end) begin
      if (has_bytes_nxt) begin
        kind_v[ev_count[0]] = EV_FIELD;
        byte_v[ev_count[0]] = CH_NUL;
        ev_count            = ev_count + 2'd1;
      end
      in_quoted_nxt   = 1'b0;
      field_start_nxt = 1'b1;
      has_bytes_nxt   = 1'b0;
      done            = 1'b1;
    end

    if (!done && field_start_nxt) begin
      field_start_nxt = 1'b0;
      if (b == CH_QUOTE) begin
        in_quoted_nxt = 1'b1;
        done          = 1'b1;
      end
    end

    if (!done) begin
      if (in_quoted_nxt) begin
        if (b == CH_QUOTE) begin
          quote_pend_nxt = 1'b1;
        end else begin
          kind_v[ev_count[0]] = EV_DATA;
          byte_v[ev_count[0]] = b;
          ev_count            = ev_count + 2'd1;
          has_bytes_nxt       = 1'b1;
        end
      end else if (b == CH_COMMA || b == CH_LF) begin
        kind_v[ev_count[0]] = (b == CH_COMMA) ? EV_FIELD : EV_ROW;
        byte_v[ev_count[0]] = CH_NUL;
        ev_count            = ev_count + 2'd1;
        has_bytes_nxt       = 1'b0;
        field_start_nxt     = 1'b1;
      end else if (b == CH_CR) begin
        cr_pend_nxt = 1'b1;
      end else begin
        kind_v[ev_count[0]] = EV_DATA;
        byte_v[ev_count[0]] = b;
        ev_count            = ev_count + 2'd1;
        has_bytes_nxt       = 1'b1;
      end
    end

    push_plan.two_events = ev_count[1];
    push_plan.kind0      = kind_v[0];
    push_plan.byte0      = byte_v[0];
    push_plan.kind1      = kind_v[1];
    push_plan.byte1      = byte_v[1];
  end

  // The queue must have room before any byte is taken, even one without events.
  assign in_ch.ready = push_ready;
  assign accept      = in_ch.valid && push_ready;
  assign push_valid  = accept && (ev_count != 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_quoted_r   <= 1'b0;
      field_start_r <= 1'b1;
      quote_pend_r  <= 1'b0;
      cr_pend_r     <= 1'b0;
      has_bytes_r   <= 1'b0;
    end else if (accept) begin
      in_quoted_r   <= in_quoted_nxt;
      field_start_r <= field_start_nxt;
      quote_pend_r  <= quote_pend_nxt;
      cr_pend_r     <= cr_pend_nxt;
      has_bytes_r   <= has_bytes_nxt;
    end
  end

endmodule

### hdl/csvt_queue.sv
// Small FIFO of event plans between the front end and the back end.
module csvt_queue import csvt_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  plan_t push_plan,
  input  logic  push_valid,
  output logic  push_ready,
  output plan_t pop_plan,
  output logic  pop_valid,
  input  logic  pop_ready
);

  plan_t                 entries_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_AW:0]     count_r, count_nxt;
  logic                  do_push, do_pop;

  assign push_ready = (count_r != QUEUE_DEPTH[QUEUE_AW:0]);
  assign pop_valid  = (count_r != '0);
  assign pop_plan   = entries_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!do_push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries_r[wr_ptr_r] <= push_plan;
    end
  end

endmodule

### hdl/csvt_back.sv
// Back end: plays out the one or two events of each plan on the result channel.
module csvt_back import csvt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  plan_t       pop_plan,
  input  logic        pop_valid,
  output logic        pop_ready,
  csvt_out_if.source  out_ch
);

  logic second_r, second_nxt;
  logic is_last;
  logic out_fire;

  assign is_last  = second_r || !pop_plan.two_events;
  assign out_fire = out_ch.valid && out_ch.ready;

  assign out_ch.valid       = pop_valid;
  assign out_ch.event_kind  = second_r ? pop_plan.kind1 : pop_plan.kind0;
  assign out_ch.data_byte   = second_r ? pop_plan.byte1 : pop_plan.byte0;
  assign out_ch.last_of_run = is_last;
  assign pop_ready          = out_ch.ready && is_last;

  always_comb begin
    second_nxt = second_r;
    if (out_fire) begin
      second_nxt = !is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      second_r <= 1'b0;
    end else begin
      second_r <= second_nxt;
    end
  end

endmodule

### hdl/csv_field_tokenizer.sv
// Top level of the streaming CSV field tokenizer.
//
// The block takes CSV text on in_ch, one byte per transaction, with
// end_of_input (or a zero byte) closing the input. It emits events on
// out_ch: a field data byte, an end of field, or an end of field and row.
// A byte causes zero, one or two events; last_of_run marks the final
// event that a byte caused.
// The front end accepts one byte every cycle while the queue has room, and
// updates the parser flags in that same cycle, so a byte can follow in the
// next cycle. Its events go into a four-entry plan queue; the back end plays
// each plan out at one event per cycle while out_ch is ready. A byte's plan
// is registered in the queue before its first event shows on out_ch. A byte
// with two events holds the back end for both; the queue absorbs bursts.
// When out_ch stalls, the queue fills and in_ch.ready drops once it holds
// four plans; a stalled event holds its value until taken.
// Synchronous reset clears the flags and empties the queue; there is no
// clearing pass, so the block is ready as soon as reset is released.
module csv_field_tokenizer import csvt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  csvt_in_if.sink     in_ch,
  csvt_out_if.source  out_ch
);

  // Plan from the front end toward the queue.
  plan_t push_plan;
  logic  push_valid;
  logic  push_ready;

  // Head of the queue toward the back end.
  plan_t pop_plan;
  logic  pop_valid;
  logic  pop_ready;

  // Byte classification and parser flags.
  csvt_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .push_plan  (push_plan),
    .push_valid (push_valid),
    .push_ready (push_ready)
  );

  // Decoupling queue; its registered head also isolates the two channels.
  csvt_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_plan  (push_plan),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .pop_plan   (pop_plan),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready)
  );

  // Event sequencing onto the result channel.
  csvt_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_plan  (pop_plan),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .out_ch    (out_ch)
  );

endmodule

### hdl/csvt_checker.sv
// Port-level checker for the CSV field tokenizer and its bind statement.
`include "csv_field_tokenizer_assert.svh"

module csvt_checker import csvt_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] event_kind,
  input logic [7:0] data_byte,
  input logic       last_of_run
);

  // Nothing is offered in the cycle after reset.
  `CSVT_ASSERT_ALWAYS(a_idle_after_reset, !rst_n |=> !out_valid)

  // A stalled transaction keeps its payload.
  `CSVT_ASSERT(a_stall_holds, out_valid && !out_ready |=> out_valid && $stable(event_kind) && $stable(data_byte) && $stable(last_of_run))

  // Field and row ends carry a zero byte.
  `CSVT_ASSERT(a_end_zero_byte, out_valid && event_kind != EV_DATA |-> data_byte == CH_NUL)

  // A field or row end is always the final event that its byte caused.
  `CSVT_ASSERT(a_end_is_last, out_valid && event_kind != EV_DATA |-> last_of_run)

endmodule

bind csv_field_tokenizer csvt_checker u_csvt_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .event_kind  (out_ch.event_kind),
  .data_byte   (out_ch.data_byte),
  .last_of_run (out_ch.last_of_run)
);

### tb/tb_top.sv
// Self-checking testbench for the streaming CSV field tokenizer.
`timescale 1ns / 100ps

module tb_top;
  import csvt_pkg::*;

  // One expected or observed event on the result channel.
  typedef struct packed {
    event_kind_t kind;
    logic [7:0]  data;
    logic        ends_run;
  } token_t;

  // One input transaction. Directed rows may carry their expected events
  // typed in (typed = 1, count events in t0 and t1); every other row is
  // checked against the tokenizer model below.
  typedef struct packed {
    logic [7:0] text;
    logic       eoi;
    logic       typed;
    logic [1:0] count;
    token_t     t0;
    token_t     t1;
  } stim_t;

  localparam token_t NO_TOKEN = '{EV_DATA, 8'h00, 1'b0};

  localparam int RANDOM_ITEMS = 1600;
  localparam int CYCLE_LIMIT  = 100000;
  localparam int DRAIN_CYCLES = 20;

  // The sender runs without gaps for a stretch of transactions, and pauses
  // once until the result channel has delivered everything it owes.
  localparam int TX_QUIET_FROM = 700;
  localparam int TX_QUIET_TO   = 950;
  localparam int TX_DRAIN_AT   = 1200;

  // The receiver holds off for a long stretch, and later never stalls for a
  // while. Both windows are counted in receiver cycles.
  localparam int RX_HOLD_FROM  = 1200;
  localparam int RX_HOLD_LEN   = 200;
  localparam int RX_QUIET_FROM = 2500;
  localparam int RX_QUIET_TO   = 3200;

  localparam int DIR_ROWS = 27;

  // Directed stimulus. It starts from reset and ends with an end of input,
  // so the random part also starts from the reset state.
  localparam stim_t DIRECTED [DIR_ROWS] = '{
    // Plain bytes, the extremes of the byte range, a comma and an LF.
    '{8'h61,    1'b0, 1'b1, 2'd1, '{EV_DATA, 8'h61, 1'b1}, NO_TOKEN},
    '{8'hFF,    1'b0, 1'b1, 2'd1, '{EV_DATA, 8'hFF, 1'b1}, NO_TOKEN},
    '{CH_COMMA, 1'b0, 1'b1, 2'd1, '{EV_FIELD, 8'h00, 1'b1}, NO_TOKEN},
    '{8'h01,    1'b0, 1'b1, 2'd1, '{EV_DATA, 8'h01, 1'b1}, NO_TOKEN},
    '{CH_LF,    1'b0, 1'b1, 2'd1, '{EV_ROW, 8'h00, 1'b1}, NO_TOKEN},
    // An opening quote produces nothing by itself.
    '{CH_QUOTE, 1'b0, 1'b1, 2'd0, NO_TOKEN, NO_TOKEN},
    // Comma, LF and CR inside quotes are data; then a doubled quote.
    '{CH_COMMA, 1'b0, 1'b0, 2'd0, NO_TOKEN, NO_TOKEN},
    '{CH_LF,    1'b0, 1'b0, 2'd0, NO_TOKEN, NO_TOKEN},
    '{CH_CR,    1'b0, 1'b0, 2'd0, NO_TOKEN, NO_TOKEN},
    '{CH_QUOTE, 1'b0, 1'b0, 2'd0, NO_TOKEN, NO_TOKEN},
    '{CH_QUOTE, 1'b0, 1'b0, 2'd0, NO_TOKEN, NO_TOKEN},
    // Closing quote, then a byte that stays in the same field.
    '{CH_QUOTE, 1'b0, 1'b0, 2'd0, NO_TOKEN, NO_TOKEN},
    '{8'h78,    1'b0, 1'b0, 2'd0, NO_TOKEN, NO_TOKEN},
    // CR LF ends the row.
    '{CH_CR,    1'b0, 1'b0, 2'd0, NO_TOKEN, NO_TOKEN},
    '{CH_LF,    1'b0, 1'b0, 2'd0, NO_TOKEN, NO_TOKEN},
    // A quote inside an unquoted field is data.
    '{8'h62,    1'b0, 1'b0, 2'd0, NO_TOKEN, NO_TOKEN},
    '{CH_QUOTE, 1'b0, 1'b0, 2'd0, NO_TOKEN, NO_TOKEN},
    // A lone CR is data and comes out together with the next byte.
    '{CH_CR,    1'b0, 1'b0, 2'd0, NO_TOKEN, NO_TOKEN},
    '{8'h63,    1'b0, 1'b0, 2'd0, NO_TOKEN, NO_TOKEN},
    // Pending CR at the end of input: CR as data, then the field ends.
    '{CH_CR,    1'b0, 1'b0, 2'd0, NO_TOKEN, NO_TOKEN},
    '{8'hAB,    1'b1, 1'b0, 2'd0, NO_TOKEN, NO_TOKEN},
    // Empty quoted field closed by a zero byte with a quote pending.
    '{CH_QUOTE, 1'b0, 1'b0, 2'd0, NO_TOKEN, NO_TOKEN},
    '{CH_QUOTE, 1'b0, 1'b0, 2'd0, NO_TOKEN, NO_TOKEN},
    '{CH_NUL,   1'b0, 1'b1, 2'd0, NO_TOKEN, NO_TOKEN},
    // Unterminated quoted field at the end still yields its field end.
    '{CH_QUOTE, 1'b0, 1'b0, 2'd0, NO_TOKEN, NO_TOKEN},
    '{8'h80,    1'b0, 1'b0, 2'd0, NO_TOKEN, NO_TOKEN},
    '{8'h7F,    1'b1, 1'b1, 2'd1, '{EV_FIELD, 8'h00, 1'b1}, NO_TOKEN}
  };

  logic clk;
  logic rst_n;

  csvt_in_if  in_ch ();
  csvt_out_if out_ch ();

  csv_field_tokenizer dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #2 clk = ~clk;

  stim_t  byte_stream[$];      // transactions still to be offered
  stim_t  cur_item;            // transaction currently on in_ch
  token_t expected_tokens[$];  // events owed by the block, oldest first
  token_t step_tokens[$];      // events of the byte just tokenized
  int     errors;

  // Model state of the tokenizer.
  logic quoted_mode;
  logic field_start;
  logic quote_held;
  logic cr_held;
  logic field_filled;

  function automatic void clear_model();
    quoted_mode  = 1'b0;
    field_start  = 1'b1;
    quote_held   = 1'b0;
    cr_held      = 1'b0;
    field_filled = 1'b0;
  endfunction

  function automatic void emit_token(event_kind_t kind, logic [7:0] data);
    token_t t;
    t.kind     = kind;
    t.data     = (kind == EV_DATA) ? data : 8'h00;
    t.ends_run = 1'b0;
    step_tokens = {step_tokens, t};
  endfunction

  function automatic void emit_data(logic [7:0] data);
    emit_token(EV_DATA, data);
    field_filled = 1'b1;
  endfunction

  function automatic void emit_end(event_kind_t kind);
    emit_token(kind, 8'h00);
    field_filled = 1'b0;
    field_start  = 1'b1;
  endfunction

  // Works out the events that one accepted byte causes and advances the
  // model state. The events land in step_tokens.
  function automatic void tokenize_byte(logic [7:0] b, logic eoi);
    logic fin;
    logic done;
    fin  = eoi || (b == CH_NUL);
    done = 1'b0;
    step_tokens.delete();

    // The byte held back last time is resolved first.
    if (quote_held) begin
      quote_held = 1'b0;
      if (!fin && b == CH_QUOTE) begin
        emit_data(CH_QUOTE);
        done = 1'b1;
      end else begin
        quoted_mode = 1'b0;
      end
    end else if (cr_held) begin
      cr_held = 1'b0;
      if (!fin && b == CH_LF) begin
        emit_end(EV_ROW);
        done = 1'b1;
      end else begin
        emit_data(CH_CR);
      end
    end

    if (!done && fin) begin
      if (field_filled) begin
        emit_token(EV_FIELD, 8'h00);
      end
      clear_model();
      done = 1'b1;
    end

    if (!done && field_start) begin
      field_start = 1'b0;
      if (b == CH_QUOTE) begin
        quoted_mode = 1'b1;
        done = 1'b1;
      end
    end

    if (!done) begin
      if (quoted_mode) begin
        if (b == CH_QUOTE) begin
          quote_held = 1'b1;
        end else begin
          emit_data(b);
        end
      end else if (b == CH_COMMA) begin
        emit_end(EV_FIELD);
      end else if (b == CH_LF) begin
        emit_end(EV_ROW);
      end else if (b == CH_CR) begin
        cr_held = 1'b1;
      end else begin
        emit_data(b);
      end
    end

    if (step_tokens.size() > 0) begin
      step_tokens[step_tokens.size() - 1].ends_run = 1'b1;
    end
  endfunction

  function automatic void add_byte(logic [7:0] b, logic eoi);
    stim_t s;
    s = '{b, eoi, 1'b0, 2'd0, NO_TOKEN, NO_TOKEN};
    byte_stream = {byte_stream, s};
  endfunction

  // Sender. A new transaction is chosen only when the bus is free or the
  // current one has just been taken, so valid never drops under a stall.
  int   sent_count;
  logic drain_wait;

  always @(posedge clk) begin : sender
    stim_t nxt;
    logic  gap;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      sent_count  = 0;
      drain_wait  = 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        sent_count = sent_count + 1;
        if (sent_count == TX_DRAIN_AT) begin
          drain_wait = 1'b1;
        end
      end else if (drain_wait && expected_tokens.size() == 0) begin
        // Everything owed so far has come out; resume sending.
        drain_wait = 1'b0;
      end

      if (!in_ch.valid || in_ch.ready) begin
        if (sent_count >= TX_QUIET_FROM && sent_count < TX_QUIET_TO) begin
          gap = 1'b0;
        end else begin
          gap = ($urandom_range(0, 99) < 28);
        end
        if (byte_stream.size() == 0 || gap || drain_wait) begin
          in_ch.valid <= 1'b0;
        end else begin
          nxt = byte_stream.pop_front();
          cur_item           <= nxt;
          in_ch.valid        <= 1'b1;
          in_ch.text_byte    <= nxt.text;
          in_ch.end_of_input <= nxt.eoi;
        end
      end
    end
  end

  // Receiver. It stalls at random, except during the quiet window, and
  // holds ready low for a long stretch so that the plan queue fills up and
  // the block has to stall its input.
  int rx_cycle;

  always @(posedge clk) begin
    rx_cycle = rx_cycle + 1;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (rx_cycle >= RX_HOLD_FROM && rx_cycle < RX_HOLD_FROM + RX_HOLD_LEN) begin
      out_ch.ready <= 1'b0;
    end else if (rx_cycle >= RX_QUIET_FROM && rx_cycle < RX_QUIET_TO) begin
      out_ch.ready <= 1'b1;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= 28);
    end
  end

  // Scoreboard. Input transactions are predicted before output transactions
  // are checked, both in this one process, so the queue never races.
  always @(posedge clk) begin : scoreboard
    token_t want;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        tokenize_byte(cur_item.text, cur_item.eoi);
        if (cur_item.typed) begin
          // Typed rows still run through the model to keep its state.
          if (cur_item.count > 0) begin
            expected_tokens = {expected_tokens, cur_item.t0};
          end
          if (cur_item.count > 1) begin
            expected_tokens = {expected_tokens, cur_item.t1};
          end
        end else begin
          foreach (step_tokens[i]) begin
            expected_tokens = {expected_tokens, step_tokens[i]};
          end
        end
      end

      if (out_ch.valid && out_ch.ready) begin
        if (expected_tokens.size() == 0) begin
          $display("%0t: unexpected event, expected none, actual kind %0d byte %0h last %0d",
                   $time, out_ch.event_kind, out_ch.data_byte, out_ch.last_of_run);
          errors = errors + 1;
        end else begin
          want = expected_tokens.pop_front();
          if (out_ch.event_kind !== want.kind) begin
            $display("%0t: event_kind mismatch, expected %0d, actual %0d",
                     $time, want.kind, out_ch.event_kind);
            errors = errors + 1;
          end
          if (out_ch.data_byte !== want.data) begin
            $display("%0t: data_byte mismatch, expected %0h, actual %0h",
                     $time, want.data, out_ch.data_byte);
            errors = errors + 1;
          end
          if (out_ch.last_of_run !== want.ends_run) begin
            $display("%0t: last_of_run mismatch, expected %0d, actual %0d",
                     $time, want.ends_run, out_ch.last_of_run);
            errors = errors + 1;
          end
        end
      end
    end
  end

  // Watchdog on the whole run.
  int cycle_count;

  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    int         rows;
    int         fields;
    int         len;
    bit         quoted;
    logic [7:0] c;

    clk                = 1'b0;
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.text_byte    = 8'h00;
    in_ch.end_of_input = 1'b0;
    out_ch.ready       = 1'b0;
    cur_item           = '0;
    errors             = 0;
    rx_cycle           = 0;
    cycle_count        = 0;
    clear_model();

    for (int i = 0; i < DIR_ROWS; i++) begin
      byte_stream = {byte_stream, DIRECTED[i]};
    end

    // Random part: mostly well-formed records of rows and fields with random
    // content, some of them broken by a missing closing quote, mixed with
    // bursts of raw random bytes.
    while (byte_stream.size() < DIR_ROWS + RANDOM_ITEMS) begin
      if ($urandom_range(0, 99) < 80) begin
        rows = $urandom_range(1, 3);
        for (int r = 0; r < rows; r++) begin
          fields = $urandom_range(1, 4);
          for (int f = 0; f < fields; f++) begin
            quoted = ($urandom_range(0, 2) == 0);
            len    = $urandom_range(0, 5);
            if (quoted) begin
              add_byte(CH_QUOTE, 1'b0);
            end
            for (int k = 0; k < len; k++) begin
              if (quoted && $urandom_range(0, 3) == 0) begin
                // Separators and quotes inside quotes; a quote is doubled.
                case ($urandom_range(0, 3))
                  0: c = CH_COMMA;
                  1: c = CH_LF;
                  2: c = CH_CR;
                  default: c = CH_QUOTE;
                endcase
              end else begin
                c = 8'($urandom_range(1, 255));
              end
              if (quoted) begin
                if (c == CH_QUOTE) begin
                  add_byte(CH_QUOTE, 1'b0);
                end
              end else if (c == CH_COMMA || c == CH_LF || c == CH_CR ||
                           (c == CH_QUOTE && k == 0)) begin
                // Keep unquoted fields intact; a quote later on is data.
                c = 8'h41 + 8'($urandom_range(0, 25));
              end
              add_byte(c, 1'b0);
            end
            if (quoted && $urandom_range(0, 9) != 0) begin
              add_byte(CH_QUOTE, 1'b0);
            end
            if (f < fields - 1) begin
              add_byte(CH_COMMA, 1'b0);
            end
          end
          if (r < rows - 1 || $urandom_range(0, 2) != 0) begin
            if ($urandom_range(0, 1) == 0) begin
              add_byte(CH_CR, 1'b0);
            end
            add_byte(CH_LF, 1'b0);
          end
        end
        // The record ends by the flag with any byte, or by a zero byte.
        if ($urandom_range(0, 1) == 0) begin
          add_byte(8'($urandom_range(0, 255)), 1'b1);
        end else begin
          add_byte(CH_NUL, 1'b0);
        end
      end else begin
        len = $urandom_range(1, 12);
        for (int k = 0; k < len; k++) begin
          add_byte(8'($urandom_range(0, 255)), ($urandom_range(0, 19) == 0));
        end
      end
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Wait until every transaction has been taken, then until every
    // expected event has come out, then a little longer for strays.
    do @(posedge clk); while (byte_stream.size() != 0 || in_ch.valid);
    do @(posedge clk); while (expected_tokens.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
